/* rtl/ilp_pkg.sv */
// Shared types and constants of the integer literal parser.
package ilp_pkg;

    localparam int ChW   = 8;
    localparam int KindW = 4;
    localparam int ValW  = 64;

    typedef logic [1:0] t_radix;
    localparam t_radix RADIX_BIN = 2'd0;
    localparam t_radix RADIX_OCT = 2'd1;
    localparam t_radix RADIX_DEC = 2'd2;
    localparam t_radix RADIX_HEX = 2'd3;

    typedef logic [KindW-1:0] t_kind;
    localparam t_kind KIND_INVALID  = 4'd0;
    localparam t_kind KIND_INT8     = 4'd1;
    localparam t_kind KIND_INT16    = 4'd2;
    localparam t_kind KIND_INT32    = 4'd3;
    localparam t_kind KIND_INT64    = 4'd4;
    localparam t_kind KIND_UINT8    = 4'd5;
    localparam t_kind KIND_UINT16   = 4'd6;
    localparam t_kind KIND_UINT32   = 4'd7;
    localparam t_kind KIND_UINT64   = 4'd8;
    localparam t_kind KIND_FLOAT    = 4'd9;
    localparam t_kind KIND_OVERFLOW = 4'd10;

    // Classified character as it travels from the front to the back.
    typedef struct packed {
        logic [3:0] digit;     // digit value, meaningful when below sixteen
        logic [3:0] lt_radix;  // bit r set when the digit is valid in radix r
        logic       is_dec;
        logic       is_sign;
        logic       is_minus;
        logic       is_zero;
        logic       is_pfx;    // one of b, o, d, x
        t_radix     pfx_radix;
        logic       is_dot;
        logic       is_i;
        logic       is_u;
        logic       is_e;
        logic       last;
    } t_ilp_cls;

endpackage

/* rtl/integer_literal_parser_top.sv */
// Top level of the radix-prefixed integer literal parser.
//
//  Channel | Direction | tdata (lowest bit up)            | tlast / tuser
//  s       | in        | ch[7:0]                          | tlast = last character
//  m       | out       | kind[3:0], value[67:4], pad zero | none
//
// One character is taken in every clock cycle unless the queue is full; the
// accumulate step (a shift and add by the radix) sits in one stage of the
// back end and sets the rate. A result passes through the classifier queue,
// the end-of-literal snapshot and then the result register. Reset is
// synchronous and active low and clears all control state at once. A stalled
// result keeps the finished literal waiting in the snapshot; the back end
// still takes characters up to the next last character, and the two-entry
// queue keeps taking requests until it fills.
module integer_literal_parser_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // ch[7:0]
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata    // kind[3:0], value[67:4], zero[71:68]
);
    import ilp_pkg::*;

    logic        q_valid, q_ready;
    t_ilp_cls    q_item;
    t_kind       kind;
    logic [63:0] value;

    ilp_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_ch      (i_s_tdata),
        .i_last    (i_s_tlast),
        .o_q_valid (q_valid),
        .i_q_ready (q_ready),
        .o_q       (q_item)
    );

    ilp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .o_q_ready (q_ready),
        .i_q       (q_item),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_kind    (kind),
        .o_value   (value)
    );

    assign o_m_tdata = {4'b0, value, kind};

endmodule

/* rtl/ilp_front.sv */
// Front end: classifies each character and holds it in a two-entry queue.
module ilp_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_ch,
    input  logic              i_last,
    output logic              o_q_valid,
    input  logic              i_q_ready,
    output ilp_pkg::t_ilp_cls o_q
);
    import ilp_pkg::*;

    t_ilp_cls   cls;
    logic [5:0] dval;
    t_ilp_cls   r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    always_comb begin
        if (i_ch >= 8'h30 && i_ch <= 8'h39) begin
            dval = 6'(i_ch - 8'h30);
        end else if (i_ch >= 8'h41 && i_ch <= 8'h5A) begin
            dval = 6'(i_ch - 8'h37);
        end else if (i_ch >= 8'h61 && i_ch <= 8'h7A) begin
            dval = 6'(i_ch - 8'h57);
        end else begin
            dval = 6'd36;
        end
        cls.digit       = dval[3:0];
        cls.lt_radix[0] = dval < 6'd2;
        cls.lt_radix[1] = dval < 6'd8;
        cls.lt_radix[2] = dval < 6'd10;
        cls.lt_radix[3] = dval < 6'd16;
        cls.is_dec      = i_ch >= 8'h30 && i_ch <= 8'h39;
        cls.is_sign     = i_ch == 8'h2B || i_ch == 8'h2D;
        cls.is_minus    = i_ch == 8'h2D;
        cls.is_zero     = i_ch == 8'h30;
        cls.is_pfx      = 1'b1;
        case (i_ch)
            8'h62:   cls.pfx_radix = RADIX_BIN;
            8'h6F:   cls.pfx_radix = RADIX_OCT;
            8'h64:   cls.pfx_radix = RADIX_DEC;
            8'h78:   cls.pfx_radix = RADIX_HEX;
            default: begin
                cls.pfx_radix = RADIX_DEC;
                cls.is_pfx    = 1'b0;
            end
        endcase
        cls.is_dot = i_ch == 8'h2E;
        cls.is_i   = i_ch == 8'h69;
        cls.is_u   = i_ch == 8'h75;
        cls.is_e   = i_ch == 8'h65;
        cls.last   = i_last;
    end

    assign o_ready   = r_cnt != 2'd2;
    assign o_q_valid = r_cnt != 2'd0;
    assign o_q       = r_q[r_rp];
    assign push      = i_valid && o_ready;
    assign pop       = o_q_valid && i_q_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
        if (push) begin
            r_q[r_wp] <= cls;
        end
    end

endmodule

/* rtl/ilp_back.sv */
// Back end: literal state machine, end-of-literal snapshot and result register.
module ilp_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    output logic                 o_q_ready,
    input  ilp_pkg::t_ilp_cls    i_q,
    output logic                 o_valid,
    input  logic                 i_ready,
    output ilp_pkg::t_kind       o_kind,
    output logic [63:0]          o_value
);
    import ilp_pkg::*;

    typedef enum logic [2:0] {
        PH_START, PH_ZERO, PH_PREFIX, PH_DIGITS, PH_SUFFIX, PH_FRAC, PH_EXP, PH_BAD
    } t_phase;

    t_phase      r_phase, n_phase, r_s_phase;
    logic        r_neg, n_neg, r_s_neg;
    t_radix      r_radix, n_radix;
    logic [63:0] r_mag, n_mag, r_s_mag;
    logic        r_ovf, n_ovf, r_s_ovf;
    logic [1:0]  r_sk, n_sk, r_s_sk;
    logic        r_s_v;
    logic        r_out_v;
    t_kind       r_kind, f_kind;
    logic [63:0] r_value, f_value;

    logic [67:0] acc;
    logic        in_radix;
    logic        pop, out_load, snap_free;
    logic [63:0] mag_z, sval;
    logic        sig_ovf;

    assign out_load  = !r_out_v || i_ready;
    assign snap_free = !r_s_v || out_load;
    assign o_q_ready = !i_q.last || snap_free;
    assign pop       = i_q_valid && o_q_ready;
    assign in_radix  = i_q.lt_radix[r_radix];

    // Multiply by the radix with shifts; any carry beyond 64 bits is overflow.
    always_comb begin
        case (r_radix)
            RADIX_BIN: acc = {3'b0, r_mag, 1'b0};
            RADIX_OCT: acc = {1'b0, r_mag, 3'b0};
            RADIX_DEC: acc = {1'b0, r_mag, 3'b0} + {3'b0, r_mag, 1'b0};
            default:   acc = {r_mag, 4'b0};
        endcase
        acc = acc + {64'b0, i_q.digit};
    end

    always_comb begin
        n_phase = r_phase;
        n_neg   = r_neg;
        n_radix = r_radix;
        n_mag   = r_mag;
        n_ovf   = r_ovf;
        n_sk    = r_sk;
        unique case (r_phase)
            PH_START: begin
                if (i_q.is_sign && r_sk == 2'd0) begin
                    n_neg = r_neg | i_q.is_minus;
                    n_sk  = 2'd1;
                end else if (i_q.is_zero) begin
                    n_phase = PH_ZERO;
                    n_sk    = 2'd0;
                end else if (i_q.is_dec) begin
                    n_phase = PH_DIGITS;
                    n_sk    = 2'd0;
                    n_mag   = {60'b0, i_q.digit};
                end else begin
                    n_phase = PH_BAD;
                end
            end
            PH_ZERO: begin
                if (i_q.is_pfx) begin
                    n_radix = i_q.pfx_radix;
                    n_phase = PH_PREFIX;
                end else if (i_q.is_dot) begin
                    n_phase = PH_FRAC;
                end else begin
                    n_phase = PH_BAD;
                end
            end
            PH_PREFIX: begin
                if (in_radix) begin
                    n_phase = PH_DIGITS;
                    n_mag   = {60'b0, i_q.digit};
                end else begin
                    n_phase = PH_BAD;
                end
            end
            PH_DIGITS: begin
                if (in_radix) begin
                    n_mag = acc[63:0];
                    n_ovf = r_ovf | (|acc[67:64]);
                end else if (i_q.is_i) begin
                    n_phase = PH_SUFFIX;
                    n_sk    = 2'd1;
                end else if (i_q.is_u) begin
                    n_phase = PH_SUFFIX;
                    n_sk    = 2'd2;
                end else if (i_q.is_dot) begin
                    n_phase = PH_FRAC;
                end else if (i_q.is_e && r_radix == RADIX_DEC) begin
                    n_phase = PH_EXP;
                    n_sk    = 2'd0;
                end else begin
                    n_phase = PH_BAD;
                end
            end
            PH_FRAC: begin
                if (!in_radix) begin
                    n_phase = PH_BAD;
                end
            end
            PH_EXP: begin
                // The sub-state tracks the exponent tail: empty, digits or
                // sign seen, inner sign waiting for digits, trailing digits.
                case (r_sk)
                    2'd0: begin
                        if (i_q.is_sign || i_q.is_dec) n_sk = 2'd1;
                        else n_phase = PH_BAD;
                    end
                    2'd1: begin
                        if (i_q.is_sign) n_sk = 2'd2;
                        else if (!i_q.is_dec) n_phase = PH_BAD;
                    end
                    2'd2: begin
                        if (i_q.is_dec) n_sk = 2'd3;
                        else n_phase = PH_BAD;
                    end
                    default: begin
                        if (!i_q.is_dec) n_phase = PH_BAD;
                    end
                endcase
            end
            PH_SUFFIX: n_phase = PH_BAD;
            PH_BAD:    n_phase = PH_BAD;
        endcase
    end

    // Result from the snapshot of a finished literal.
    always_comb begin
        f_kind  = KIND_INVALID;
        f_value = 64'b0;
        mag_z   = (r_s_phase == PH_ZERO) ? 64'b0 : r_s_mag;
        sval    = r_s_neg ? (64'b0 - mag_z) : mag_z;
        sig_ovf = r_s_ovf || (r_s_neg ? (mag_z[63] && (|mag_z[62:0])) : mag_z[63]);
        case (r_s_phase)
            PH_FRAC: f_kind = KIND_FLOAT;
            PH_EXP: begin
                if (r_s_sk == 2'd1 || r_s_sk == 2'd3) f_kind = KIND_FLOAT;
            end
            PH_ZERO, PH_DIGITS, PH_SUFFIX: begin
                if (r_s_phase == PH_SUFFIX && r_s_sk == 2'd2) begin
                    if (!r_s_neg) begin
                        if (r_s_ovf) begin
                            f_kind = KIND_OVERFLOW;
                        end else begin
                            f_value = mag_z;
                            if (|mag_z[63:32])      f_kind = KIND_UINT64;
                            else if (|mag_z[31:16]) f_kind = KIND_UINT32;
                            else if (|mag_z[15:8])  f_kind = KIND_UINT16;
                            else                    f_kind = KIND_UINT8;
                        end
                    end
                end else if (sig_ovf) begin
                    f_kind = KIND_OVERFLOW;
                end else begin
                    f_value = sval;
                    if ((&sval[63:7]) || !(|sval[63:7]))        f_kind = KIND_INT8;
                    else if ((&sval[63:15]) || !(|sval[63:15])) f_kind = KIND_INT16;
                    else if ((&sval[63:31]) || !(|sval[63:31])) f_kind = KIND_INT32;
                    else                                        f_kind = KIND_INT64;
                end
            end
            default: f_kind = KIND_INVALID;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_neg   <= 1'b0;
            r_radix <= RADIX_DEC;
            r_mag   <= 64'b0;
            r_ovf   <= 1'b0;
            r_sk    <= 2'd0;
            r_s_v   <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            if (pop) begin
                if (i_q.last) begin
                    r_phase <= PH_START;
                    r_neg   <= 1'b0;
                    r_radix <= RADIX_DEC;
                    r_mag   <= 64'b0;
                    r_ovf   <= 1'b0;
                    r_sk    <= 2'd0;
                end else begin
                    r_phase <= n_phase;
                    r_neg   <= n_neg;
                    r_radix <= n_radix;
                    r_mag   <= n_mag;
                    r_ovf   <= n_ovf;
                    r_sk    <= n_sk;
                end
            end
            if (pop && i_q.last) begin
                r_s_v <= 1'b1;
            end else if (out_load) begin
                r_s_v <= 1'b0;
            end
            if (out_load) begin
                r_out_v <= r_s_v;
            end
        end
        if (pop && i_q.last) begin
            r_s_phase <= n_phase;
            r_s_neg   <= n_neg;
            r_s_mag   <= n_mag;
            r_s_ovf   <= n_ovf;
            r_s_sk    <= n_sk;
        end
        if (out_load && r_s_v) begin
            r_kind  <= f_kind;
            r_value <= f_value;
        end
    end

    assign o_valid = r_out_v;
    assign o_kind  = r_kind;
    assign o_value = r_value;

endmodule

/* rtl/ilp_checker.sv */
// Port-level checks of the literal parser and their attachment to the top level.
module ilp_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [71:0] o_m_tdata
);
    import ilp_pkg::*;

    logic [3:0]  kind;
    logic [63:0] value;
    assign kind  = o_m_tdata[3:0];
    assign value = o_m_tdata[67:4];

    a_reset_clears_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    a_no_value_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (kind == KIND_INVALID || kind == KIND_FLOAT ||
                       kind == KIND_OVERFLOW) |-> value == 64'b0)
        else $error("value given with a code that carries none");

    a_uint8_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && kind == KIND_UINT8 |-> value[63:8] == 56'b0)
        else $error("uint8 result out of range");

    a_int8_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && kind == KIND_INT8 |->
            (value[63:7] == 57'b0 || value[63:7] == {57{1'b1}}))
        else $error("int8 result out of range");

endmodule

bind integer_literal_parser_top ilp_checker u_ilp_checker (.*);
